[rtl/stwa_pkg.sv]
// Package for the subscriber table with aging: widths, constants, opcode and
// state enums, and the command, entry and result structs used across the modules.
// No dependencies.
package stwa_pkg;

  localparam int unsigned SLOTS_DEF     = 64;
  localparam int unsigned MAX_RESULTS   = 64;
  localparam int unsigned CNT_W         = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IP_W          = 32;
  localparam int unsigned PORT_W        = 16;
  localparam int unsigned TIME_W        = 32;
  localparam int unsigned TMO_W         = 16;
  localparam int unsigned SIDX_W        = 6;
  localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd10;

  typedef enum logic {
    OP_REFRESH = 1'b0,
    OP_BCAST   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_FLUSH
  } eng_state_e;

  typedef struct packed {
    op_e               op;
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] now;
  } cmd_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [TIME_W-1:0] seen;
  } entry_t;

  typedef struct packed {
    logic [IP_W-1:0]   ip;
    logic [PORT_W-1:0] port;
    logic [SIDX_W-1:0] slot_index;
    logic              none_live;
    logic              last;
  } res_t;

endpackage

[rtl/stwa_front.sv]
// Front end: accepts input items, decodes the opcode into a command and holds
// up to two commands for the table engine. Depends on stwa_pkg.
module stwa_front import stwa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  output logic              full_o,
  input  logic              opcode_i,
  input  logic [IP_W-1:0]   client_ip_i,
  input  logic [PORT_W-1:0] client_port_i,
  input  logic [TIME_W-1:0] now_seconds_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  cmd_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = buf_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  // Classify the item.
  always_comb begin
    cmd_in.op   = opcode_i ? OP_BCAST : OP_REFRESH;
    cmd_in.ip   = client_ip_i;
    cmd_in.port = client_port_i;
    cmd_in.now  = now_seconds_i;
  end

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

[rtl/stwa_engine.sv]
// Table engine: slot memory, valid bits and the slot walk for refresh and
// broadcast commands. Depends on stwa_pkg.
module stwa_engine import stwa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [TMO_W-1:0] timeout_i,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_pop_o,
  output logic             res_push_o,
  output res_t             res_o,
  input  logic             res_full_i
);

  localparam int unsigned IdxW = $clog2(SLOTS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOTS - 1);

  eng_state_e       state_q, state_d;
  logic [IdxW-1:0]  idx_q;
  cmd_t             cmd_q;
  entry_t           rd_q;
  entry_t           mem [SLOTS];
  logic [SLOTS-1:0] valid_q;
  logic             free_found_q;
  logic [IdxW-1:0]  free_idx_q;
  logic             pend_valid_q;
  res_t             pend_q;
  logic [CNT_W-1:0] cnt_q;

  logic              slot_v, hit, expired, take, stall, last_slot, is_bcast;
  logic [TIME_W-1:0] age;
  logic [IdxW+SIDX_W-1:0] idx_ext;
  logic              mem_we, mem_re, valid_clr;
  logic [IdxW-1:0]   mem_waddr;
  entry_t            mem_wdata;

  assign is_bcast  = (cmd_q.op == OP_BCAST);
  assign slot_v    = valid_q[idx_q];
  assign hit       = slot_v && (rd_q.ip == cmd_q.ip) && (rd_q.port == cmd_q.port);
  assign age       = cmd_q.now - rd_q.seen;
  assign expired   = slot_v && (age > {{(TIME_W-TMO_W){1'b0}}, timeout_i});
  assign take      = slot_v && !expired && (cnt_q < CNT_W'(MAX_RESULTS));
  assign stall     = is_bcast && take && pend_valid_q && res_full_i;
  assign last_slot = (idx_q == LastIdx);
  assign idx_ext   = {{SIDX_W{1'b0}}, idx_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) state_d = ST_READ;
      end
      ST_READ: state_d = ST_EVAL;
      ST_EVAL: begin
        if (!is_bcast) begin
          state_d = (hit || last_slot) ? ST_IDLE : ST_READ;
        end else if (!stall) begin
          state_d = last_slot ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!res_full_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    cmd_pop_o  = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = '{ip: cmd_q.ip, port: cmd_q.port, seen: cmd_q.now};
    valid_clr  = 1'b0;
    res_push_o = 1'b0;
    res_o      = pend_q;
    res_o.last = 1'b0;
    case (state_q)
      ST_IDLE: cmd_pop_o = cmd_valid_i;
      ST_READ: mem_re = 1'b1;
      ST_EVAL: begin
        if (!is_bcast) begin
          if (hit) begin
            mem_we = 1'b1;
          end else if (last_slot && (free_found_q || !slot_v)) begin
            // Fill the lowest free slot.
            mem_we    = 1'b1;
            mem_waddr = free_found_q ? free_idx_q : idx_q;
          end
        end else begin
          valid_clr = expired;
          // Release the held result once the next live slot is known.
          res_push_o = take && pend_valid_q && !res_full_i;
        end
      end
      ST_FLUSH: begin
        res_push_o = !res_full_i;
        if (pend_valid_q) begin
          res_o.last = 1'b1;
        end else begin
          res_o = '{ip: '0, port: '0, slot_index: '0, none_live: 1'b1, last: 1'b1};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      idx_q        <= '0;
      valid_q      <= '0;
      free_found_q <= 1'b0;
      pend_valid_q <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q <= state_d;
      if (valid_clr) valid_q[idx_q] <= 1'b0;
      if (mem_we)    valid_q[mem_waddr] <= 1'b1;
      case (state_q)
        ST_IDLE: begin
          idx_q        <= '0;
          free_found_q <= 1'b0;
          pend_valid_q <= 1'b0;
          cnt_q        <= '0;
        end
        ST_EVAL: begin
          if (!stall) begin
            idx_q <= idx_q + 1'b1;
            if (!is_bcast && !slot_v) free_found_q <= 1'b1;
            if (is_bcast && take) begin
              pend_valid_q <= 1'b1;
              cnt_q        <= cnt_q + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && cmd_valid_i) cmd_q <= cmd_i;
    if (state_q == ST_EVAL && !is_bcast && !slot_v && !free_found_q) free_idx_q <= idx_q;
    if (state_q == ST_EVAL && is_bcast && take && !stall) begin
      pend_q <= '{ip: rd_q.ip, port: rd_q.port, slot_index: idx_ext[SIDX_W-1:0],
                  none_live: 1'b0, last: 1'b0};
    end
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_q <= mem[idx_q];
  end

endmodule

[rtl/stwa_resq.sv]
// Result queue: holds up to two result items between the engine and the
// output side. Depends on stwa_pkg.
module stwa_resq import stwa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  res_t       buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = buf_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

[rtl/subscriber_table_with_aging.sv]
// Subscriber table with aging. A refresh item walks the slots one at a time
// (registered read of the slot memory, then compare) until a hit or the last slot;
// a broadcast walks every slot, then flushes, and can stall on the result side.
// Items are handled one at a time by the engine; up to two more wait in the front queue.
// Reset clears all valid bits at once and sets the timeout to 10; no sweep.
module subscriber_table_with_aging import stwa_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input queue side
  input  logic              push,
  output logic              full,
  input  logic              opcode_i,
  input  logic [IP_W-1:0]   client_ip_i,
  input  logic [PORT_W-1:0] client_port_i,
  input  logic [TIME_W-1:0] now_seconds_i,
  // Result queue side
  output logic              empty,
  input  logic              pop,
  output logic [IP_W-1:0]   dest_ip_o,
  output logic [PORT_W-1:0] dest_port_o,
  output logic [SIDX_W-1:0] slot_index_o,
  output logic              none_live_o,
  output logic              last_o,
  // Timeout register write
  input  logic              cfg_we_i,
  input  logic [TMO_W-1:0]  cfg_wdata_i
);

  logic [TMO_W-1:0] timeout_q;
  logic             cmd_valid, cmd_pop;
  cmd_t             cmd;
  logic             res_push, res_full;
  res_t             res_eng, res_head;

  // Timeout register: to be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // Front: accept and classify items, queue them for the engine.
  stwa_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .opcode_i      (opcode_i),
    .client_ip_i   (client_ip_i),
    .client_port_i (client_port_i),
    .now_seconds_i (now_seconds_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  // Back: walk the slot table, refresh or fill, expire and emit live slots.
  stwa_engine #(
    .SLOTS (SLOTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .timeout_i   (timeout_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res_eng),
    .res_full_i  (res_full)
  );

  // Result queue: decouple the walk from the consumer.
  stwa_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_eng),
    .full_o  (res_full),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_head)
  );

  assign dest_ip_o    = res_head.ip;
  assign dest_port_o  = res_head.port;
  assign slot_index_o = res_head.slot_index;
  assign none_live_o  = res_head.none_live;
  assign last_o       = res_head.last;

endmodule

[tb/tb_subscriber_table_with_aging.sv]
// Self-checking testbench for subscriber_table_with_aging: a table predictor checks
// every broadcast result against the slot table it keeps. Depends on stwa_pkg and on
// the RTL of subscriber_table_with_aging.
module tb_subscriber_table_with_aging;
  import stwa_pkg::*;

  // Worst case for an item that gives no result: one refresh in the engine and two
  // in the front queue, each walking every slot.
  localparam int SETTLE      = 3 * (2 * SLOTS_DEF + 3) + 16;
  localparam int HOLD_CYCLES = 2000;
  localparam int LIMIT       = 400000;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              push          = 1'b0;
  logic              full;
  logic              opcode_i      = 1'b0;
  logic [IP_W-1:0]   client_ip_i   = '0;
  logic [PORT_W-1:0] client_port_i = '0;
  logic [TIME_W-1:0] now_seconds_i = '0;
  logic              empty;
  logic              pop           = 1'b0;
  logic [IP_W-1:0]   dest_ip_o;
  logic [PORT_W-1:0] dest_port_o;
  logic [SIDX_W-1:0] slot_index_o;
  logic              none_live_o;
  logic              last_o;
  logic              cfg_we_i      = 1'b0;
  logic [TMO_W-1:0]  cfg_wdata_i   = '0;

  subscriber_table_with_aging dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .client_ip_i   (client_ip_i),
    .client_port_i (client_port_i),
    .now_seconds_i (now_seconds_i),
    .empty         (empty),
    .pop           (pop),
    .dest_ip_o     (dest_ip_o),
    .dest_port_o   (dest_port_o),
    .slot_index_o  (slot_index_o),
    .none_live_o   (none_live_o),
    .last_o        (last_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Predictor copy of the subscriber table and the timeout register.
  bit                tbl_valid [SLOTS_DEF];
  logic [IP_W-1:0]   tbl_ip    [SLOTS_DEF];
  logic [PORT_W-1:0] tbl_port  [SLOTS_DEF];
  logic [TIME_W-1:0] tbl_seen  [SLOTS_DEF];
  logic [TMO_W-1:0]  timeout_s = TIMEOUT_RESET;

  cmd_t pending_q [$];   // items not yet taken by the block
  res_t fanout_q  [$];   // destinations the block still owes, oldest first
  res_t want;

  int                mismatch_cnt   = 0;
  int                cycle_cnt      = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  bit                hold_go        = 1'b0;
  bit                hold_ack       = 1'b0;
  int                hold_left      = 0;
  logic [TIME_W-1:0] wall_sec       = '0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Apply one accepted item to the table. A broadcast expires stale slots in index
  // order and queues one destination per slot that stays live.
  function automatic void table_apply(cmd_t c);
    int                free_i;
    int                n;
    bit                hit;
    logic [TIME_W-1:0] age;
    res_t              r;
    free_i = -1;
    n      = 0;
    hit    = 1'b0;
    if (c.op == OP_REFRESH) begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (!hit) begin
          if (tbl_valid[i] && tbl_ip[i] == c.ip && tbl_port[i] == c.port) begin
            tbl_seen[i] = c.now;
            hit = 1'b1;
          end else if (!tbl_valid[i] && free_i < 0) begin
            free_i = i;
          end
        end
      end
      // No match: take the lowest free slot, drop the item on a full table.
      if (!hit && free_i >= 0) begin
        tbl_valid[free_i] = 1'b1;
        tbl_ip[free_i]    = c.ip;
        tbl_port[free_i]  = c.port;
        tbl_seen[free_i]  = c.now;
      end
    end else begin
      for (int i = 0; i < SLOTS_DEF; i++) begin
        if (tbl_valid[i]) begin
          // Age wraps modulo 2^32, so a time in the future reads as very old.
          age = c.now - tbl_seen[i];
          if (age > {{(TIME_W-TMO_W){1'b0}}, timeout_s}) begin
            tbl_valid[i] = 1'b0;
          end else if (n < MAX_RESULTS) begin
            r.ip         = tbl_ip[i];
            r.port       = tbl_port[i];
            r.slot_index = SIDX_W'(i);
            r.none_live  = 1'b0;
            r.last       = 1'b0;
            fanout_q.push_back(r);
            n++;
          end
        end
      end
      if (n == 0) begin
        r = '0;
        r.none_live = 1'b1;
        r.last      = 1'b1;
        fanout_q.push_back(r);
      end else begin
        r = fanout_q.pop_back();
        r.last = 1'b1;
        fanout_q.push_back(r);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_item(input op_e op, input logic [IP_W-1:0] ip,
                            input logic [PORT_W-1:0] port, input logic [TIME_W-1:0] now);
    cmd_t c;
    c.op   = op;
    c.ip   = ip;
    c.port = port;
    c.now  = now;
    pending_q.push_back(c);
  endtask

  // Hold the sender until every item is taken and every destination has come out,
  // then let trailing refreshes finish inside the block.
  task automatic drain();
    while (pending_q.size() != 0 || fanout_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the timeout while the block is idle.
  task automatic set_timeout(input logic [TMO_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    timeout_s    = v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed traffic: refreshes from a pool of subscribers (some sharing an
  // address on different ports) on a slowly advancing clock, with broadcasts between
  // them, plus some noise items with random fields and random times.
  task automatic random_session(input int n, input int pool_n);
    logic [IP_W-1:0]   pool_ip   [$];
    logic [PORT_W-1:0] pool_port [$];
    int                k;
    int                pick;
    int                j;
    for (k = 0; k < pool_n; k++) begin
      pool_ip.push_back((k % 3 == 1) ? pool_ip[k-1] : IP_W'($urandom));
      pool_port.push_back(PORT_W'($urandom_range(0, 65535)));
    end
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(99);
      wall_sec += $urandom_range(0, 4);
      if ($urandom_range(99) < 4) wall_sec += $urandom;
      if (pick < 70) begin
        j = $urandom_range(pool_n - 1);
        queue_item(OP_REFRESH, pool_ip[j], pool_port[j], wall_sec);
      end else if (pick < 85) begin
        queue_item(OP_BCAST, $urandom, PORT_W'($urandom_range(0, 65535)), wall_sec);
      end else begin
        queue_item(op_e'($urandom_range(1)), $urandom,
                   PORT_W'($urandom_range(0, 65535)), $urandom);
      end
    end
  endtask

  // Driver: offer the oldest pending item, hold it while the block is full, and
  // predict its results on the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) table_apply(pending_q.pop_front());
      if (!(push && full)) begin
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          push          <= 1'b1;
          opcode_i      <= pending_q[0].op;
          client_ip_i   <= pending_q[0].ip;
          client_port_i <= pending_q[0].port;
          now_seconds_i <= pending_q[0].now;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, armed by toggling hold_go.
  always @(posedge clk_i) begin
    if (hold_go != hold_ack) begin
      hold_ack  <= hold_go;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each popped result with the oldest owed destination.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (fanout_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing owed: ip %h port %h slot %0d",
                                    dest_ip_o, dest_port_o, slot_index_o));
        end else begin
          want = fanout_q.pop_front();
          if (dest_ip_o !== want.ip)
            report_mismatch($sformatf("dest_ip %h, want %h", dest_ip_o, want.ip));
          if (dest_port_o !== want.port)
            report_mismatch($sformatf("dest_port %h, want %h", dest_port_o, want.port));
          if (slot_index_o !== want.slot_index)
            report_mismatch($sformatf("slot_index %0d, want %0d",
                                      slot_index_o, want.slot_index));
          if (none_live_o !== want.none_live)
            report_mismatch($sformatf("none_live %b, want %b", none_live_o, want.none_live));
          if (last_o !== want.last)
            report_mismatch($sformatf("last %b, want %b", last_o, want.last));
        end
      end
      pop <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("subscriber_table_with_aging verification failed");
      $finish;
    end
  end

  initial begin
    logic [IP_W-1:0]   keep_ip;
    logic [PORT_W-1:0] keep_port;
    int                k;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset timeout of 10 seconds, no idling.
    // Broadcast on an empty table; address and port are ignored here.
    queue_item(OP_BCAST, 32'hFFFF_FFFF, 16'hFFFF, 32'd0);
    queue_item(OP_REFRESH, 32'h0, 16'h0, 32'd0);
    queue_item(OP_REFRESH, 32'hFFFF_FFFF, 16'hFFFF, 32'd5);
    queue_item(OP_REFRESH, 32'h0, 16'hFFFF, 32'd6);
    // Same address and port again: refresh in place, no new slot.
    queue_item(OP_REFRESH, 32'h0, 16'h0, 32'd9);
    // Age equal to the timeout stays live; one second more expires.
    queue_item(OP_BCAST, 32'h0, 16'h0, 32'd15);
    queue_item(OP_BCAST, 32'h0, 16'h0, 32'd16);
    // Fill the freed slot just before the clock wraps, then walk after the wrap.
    queue_item(OP_REFRESH, 32'hFFFF_FFFF, 16'h0, 32'hFFFF_FFFE);
    queue_item(OP_BCAST, 32'h0, 16'h0, 32'd3);
    // A last-seen time in the future reads as a huge age.
    queue_item(OP_REFRESH, 32'h1234_5678, 16'hABCD, 32'd100);
    queue_item(OP_BCAST, 32'h0, 16'h0, 32'd50);
    queue_item(OP_REFRESH, 32'hA5A5_A5A5, 16'h5A5A, 32'hFFFF_FFFF);
    queue_item(OP_REFRESH, 32'h5A5A_5A5A, 16'hA5A5, 32'hFFFF_FFFF);
    queue_item(OP_BCAST, 32'h5A5A_5A5A, 16'hA5A5, 32'd9);
    queue_item(OP_BCAST, 32'hA5A5_A5A5, 16'h5A5A, 32'd10);
    queue_item(OP_REFRESH, $urandom, PORT_W'($urandom_range(0, 65535)), $urandom);
    drain();

    // Largest timeout: fill the whole table, overflow it, refresh a known subscriber,
    // then broadcast the full table while the receiver holds off so the block backs up.
    set_timeout(16'hFFFF);
    wall_sec = $urandom;
    keep_ip   = $urandom;
    keep_port = PORT_W'($urandom_range(0, 65535));
    queue_item(OP_REFRESH, keep_ip, keep_port, wall_sec);
    for (k = 1; k < 70; k++)
      queue_item(OP_REFRESH, $urandom, PORT_W'($urandom_range(0, 65535)), wall_sec + k);
    wall_sec += 80;
    queue_item(OP_BCAST, $urandom, PORT_W'($urandom_range(0, 65535)), wall_sec);
    queue_item(OP_REFRESH, keep_ip, keep_port, wall_sec);
    queue_item(OP_REFRESH, $urandom, PORT_W'($urandom_range(0, 65535)), wall_sec);
    for (k = 0; k < 4; k++)
      queue_item(OP_BCAST, $urandom, PORT_W'($urandom_range(0, 65535)), wall_sec + k);
    while (pending_q.size() > 6) @(posedge clk_i);
    hold_go <= ~hold_go;
    drain();

    // Zero timeout with a slow sender: anything older than this second expires.
    set_timeout(16'h0000);
    send_idle_pct <= 71;
    random_session(35, 12);
    drain();

    // Short timeout with a slow receiver: slots expire and get reused.
    set_timeout(TMO_W'($urandom_range(1, 30)));
    send_idle_pct  <= 0;
    recv_stall_pct <= 71;
    random_session(30, 20);
    drain();

    // Random timeout, both sides idling.
    set_timeout(TMO_W'($urandom_range(0, 65535)));
    send_idle_pct  <= 22;
    recv_stall_pct <= 22;
    random_session(30, 40);
    drain();

    if (mismatch_cnt == 0) begin
      $display("subscriber_table_with_aging verification clean");
    end else begin
      $display("subscriber_table_with_aging verification failed");
    end
    $finish;
  end

endmodule
